### rtl/ultrasonic_range_scanner_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ultrasonic range scanner.
// Each macro turns into a labeled concurrent assertion in simulation and
// into nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_RANGE_SCANNER_UNIT_MACROS_SVH
`define ULTRASONIC_RANGE_SCANNER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define URS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);
`define URS_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);
`else
`define URS_ASSERT(lbl, clk, rst_n, prop, msg)
`define URS_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

### rtl/urs_pkg.sv
// ----------------------------------------------------------------------------
// urs_pkg
// Types and constants shared by the ultrasonic range scanner modules.
// ----------------------------------------------------------------------------
`default_nettype none

package urs_pkg;

	localparam int DEF_SENSOR_COUNT = 3;
	localparam int DEF_TIMER_WIDTH  = 24;

	localparam int SENSOR_W = 2;
	localparam int TRIG_W   = 3;
	localparam int ECHO_W   = 3;
	localparam int DIST_W   = 19;
	localparam int DIGITS   = 4;
	localparam int BCD_W    = 4 * DIGITS;
	localparam int CFG_W    = 8;
	localparam int CFG_IDX_W = 1;

	localparam int DIVISOR_CM = 58;
	localparam int REM_W      = 6;

	localparam logic [7:0] ASCII_ZERO = 8'h30;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_TRIG_LOW  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIG_HIGH = 1'b1;

	localparam logic [CFG_W-1:0] TRIG_LOW_RST  = 8'd2;
	localparam logic [CFG_W-1:0] TRIG_HIGH_RST = 8'd20;

	typedef struct packed {
		logic              cmd;
		logic [ECHO_W-1:0] echo_levels;
	} item_t;

	typedef struct packed {
		logic [TRIG_W-1:0]   trigger_lines;
		logic                busy_res;
		logic                reading_valid;
		logic [SENSOR_W-1:0] sensor_number;
		logic [DIST_W-1:0]   distance_cm;
		logic [31:0]         ascii_digits;
		logic                scan_last;
	} res_t;

	// Control from the sequencer to the distance counters.
	typedef struct packed {
		logic start;
		logic inc;
	} dist_ctl_t;

	typedef struct packed {
		logic [DIST_W-1:0] cm;
		logic [BCD_W-1:0]  bcd;
	} dist_val_t;

endpackage

`default_nettype wire

### rtl/ultrasonic_range_scanner_unit.sv
// ----------------------------------------------------------------------------
// ultrasonic_range_scanner_unit
// Sequencer for up to three pulse-echo ultrasonic range sensors.
// ----------------------------------------------------------------------------
// Each input beat is one microsecond tick and a tick can be presented on
// every cycle; the result beat for a tick is written into the result buffer
// on the clock edge that takes the tick, and is presented from there. A
// two-entry result buffer holds results while the result side stalls, and
// the input side stalls only when both entries are occupied. The distance
// and its four decimal digits are counted up alongside the echo timer, so a
// reading is ready on the tick the echo falls without any division.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_range_scanner_unit #(
	parameter int SENSOR_COUNT = urs_pkg::DEF_SENSOR_COUNT,
	parameter int TIMER_WIDTH  = urs_pkg::DEF_TIMER_WIDTH
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire  [urs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire  [urs_pkg::CFG_W-1:0]      cfg_data,
	input  wire                            item_valid,
	output logic                           item_stall,
	input  urs_pkg::item_t                 item_data,
	output logic                           res_valid,
	input  wire                            res_stall,
	output urs_pkg::res_t                  res_data
);
	import urs_pkg::*;

	logic      acc;
	logic      buf_full;
	dist_ctl_t dctl;
	dist_val_t dval;
	res_t      res_c;

	assign item_stall = buf_full;
	assign acc        = item_valid && !buf_full;

	urs_seq #(
		.SENSOR_COUNT(SENSOR_COUNT),
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.acc      (acc),
		.item     (item_data),
		.dval     (dval),
		.dctl     (dctl),
		.res      (res_c)
	);

	urs_dist u_dist (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (dctl),
		.val   (dval)
	);

	urs_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (acc),
		.push_data(res_c),
		.full     (buf_full),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data (res_data)
	);

endmodule

`default_nettype wire

### rtl/urs_dist.sv
// ----------------------------------------------------------------------------
// urs_dist
// Running quotient of the echo width by 58, kept as a binary count and as a
// four digit decimal count, so no divider is needed at the end of a sensor.
// ----------------------------------------------------------------------------
`default_nettype none

module urs_dist (
	input  wire                 clk,
	input  wire                 arst_n,
	input  urs_pkg::dist_ctl_t  ctl,
	output urs_pkg::dist_val_t  val
);
	import urs_pkg::*;

	logic [REM_W-1:0]  rem_q;
	logic [DIST_W-1:0] quo_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [BCD_W-1:0]  bcd_inc;
	logic              wrap;

	assign wrap = (rem_q == REM_W'(DIVISOR_CM - 1));

	// Decimal increment with the carry rippling through the four digits.
	always_comb begin
		logic carry;
		carry = 1'b1;
		for (int k = 0; k < DIGITS; k++) begin
			if (carry && bcd_q[4*k +: 4] == 4'd9) begin
				bcd_inc[4*k +: 4] = 4'd0;
				carry = 1'b1;
			end else begin
				bcd_inc[4*k +: 4] = bcd_q[4*k +: 4] + {3'd0, carry};
				carry = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= REM_W'(1);
			quo_q <= '0;
			bcd_q <= '0;
		end else if (ctl.inc) begin
			if (wrap) begin
				rem_q <= '0;
				quo_q <= quo_q + DIST_W'(1);
				bcd_q <= bcd_inc;
			end else begin
				rem_q <= rem_q + REM_W'(1);
			end
		end
	end

	assign val.cm  = quo_q;
	assign val.bcd = bcd_q;

	// The reset only matters for the assertion; counters are loaded on start.
	logic seen_start_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_start_q <= 1'b0;
		end else if (ctl.start) begin
			seen_start_q <= 1'b1;
		end
	end

	`include "ultrasonic_range_scanner_unit_macros.svh"

	`URS_NEVER(a_inc_before_start, clk, arst_n, ctl.inc && !seen_start_q, "count before start")
	`URS_NEVER(a_start_and_inc, clk, arst_n, ctl.start && ctl.inc, "start and count together")
	`URS_NEVER(a_rem_range, clk, arst_n, seen_start_q && rem_q >= REM_W'(DIVISOR_CM), "rem range")

endmodule

`default_nettype wire

### rtl/urs_seq.sv
// ----------------------------------------------------------------------------
// urs_seq
// Per-tick ranging sequencer: trigger low and high times, echo wait and echo
// width timing for each sensor in turn, and assembly of the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module urs_seq #(
	parameter int SENSOR_COUNT = urs_pkg::DEF_SENSOR_COUNT,
	parameter int TIMER_WIDTH  = urs_pkg::DEF_TIMER_WIDTH
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire  [urs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [urs_pkg::CFG_W-1:0]       cfg_data,
	input  wire                             acc,
	input  urs_pkg::item_t                  item,
	input  urs_pkg::dist_val_t              dval,
	output urs_pkg::dist_ctl_t              dctl,
	output urs_pkg::res_t                   res
);
	import urs_pkg::*;

	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_LOW     = 3'd1;
	localparam logic [2:0] PH_HIGH    = 3'd2;
	localparam logic [2:0] PH_WAIT    = 3'd3;
	localparam logic [2:0] PH_MEASURE = 3'd4;

	localparam logic [SENSOR_W:0] LAST_BOUND = (SENSOR_W+1)'(SENSOR_COUNT);

	logic [CFG_W-1:0]       low_us_q, high_us_q;
	logic [2:0]             phase_q, phase_d;
	logic [SENSOR_W-1:0]    sensor_q, sensor_d;
	logic [7:0]             cnt_q, cnt_d, cnt_inc;
	logic [TIMER_WIDTH-1:0] timer_q, timer_d;
	logic                   echo_hi;
	logic                   rd_valid, rd_last;
	logic                   start_c, inc_c;
	logic [2:0]             begin_phase;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_us_q  <= TRIG_LOW_RST;
			high_us_q <= TRIG_HIGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TRIG_LOW:  low_us_q  <= cfg_data;
				CFG_TRIG_HIGH: high_us_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A sensor number of three has no echo line.
	assign echo_hi     = (sensor_q != 2'd3) && item.echo_levels[sensor_q];
	assign cnt_inc     = cnt_q + 8'd1;
	assign begin_phase = (low_us_q == '0) ? PH_HIGH : PH_LOW;
	assign rd_last     = ({1'b0, sensor_q} + (SENSOR_W+1)'(1)) >= LAST_BOUND;

	always_comb begin
		phase_d  = phase_q;
		sensor_d = sensor_q;
		cnt_d    = cnt_q;
		timer_d  = timer_q;
		rd_valid = 1'b0;
		start_c  = 1'b0;
		inc_c    = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (item.cmd) begin
					sensor_d = '0;
					cnt_d    = '0;
					timer_d  = '0;
					phase_d  = begin_phase;
				end
			end
			PH_LOW: begin
				cnt_d = cnt_inc;
				if (cnt_inc >= low_us_q) begin
					phase_d = PH_HIGH;
					cnt_d   = '0;
				end
			end
			PH_HIGH: begin
				cnt_d = cnt_inc;
				if (cnt_inc >= high_us_q) begin
					phase_d = PH_WAIT;
					cnt_d   = '0;
				end
			end
			PH_WAIT: begin
				if (echo_hi) begin
					timer_d = TIMER_WIDTH'(1);
					phase_d = PH_MEASURE;
					start_c = 1'b1;
				end
			end
			PH_MEASURE: begin
				if (echo_hi) begin
					// The timer saturates; the quotient stops with it.
					if (timer_q != '1) begin
						timer_d = timer_q + TIMER_WIDTH'(1);
						inc_c   = 1'b1;
					end
				end else begin
					rd_valid = 1'b1;
					cnt_d    = '0;
					timer_d  = '0;
					if (rd_last) begin
						phase_d  = PH_IDLE;
						sensor_d = '0;
					end else begin
						sensor_d = sensor_q + SENSOR_W'(1);
						phase_d  = begin_phase;
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			sensor_q <= '0;
			cnt_q    <= '0;
			timer_q  <= '0;
		end else if (acc) begin
			phase_q  <= phase_d;
			sensor_q <= sensor_d;
			cnt_q    <= cnt_d;
			timer_q  <= timer_d;
		end
	end

	assign dctl.start = acc && start_c;
	assign dctl.inc   = acc && inc_c;

	always_comb begin
		for (int k = 0; k < TRIG_W; k++) begin
			res.trigger_lines[k] = (phase_d == PH_HIGH) && (sensor_d == SENSOR_W'(k));
		end
		res.busy_res      = (phase_d != PH_IDLE);
		res.reading_valid = rd_valid;
		res.sensor_number = rd_valid ? sensor_q : '0;
		res.distance_cm   = rd_valid ? dval.cm : '0;
		for (int k = 0; k < DIGITS; k++) begin
			res.ascii_digits[8*k +: 8] = rd_valid ?
				(ASCII_ZERO | {4'd0, dval.bcd[4*k +: 4]}) : 8'd0;
		end
		res.scan_last     = rd_valid && rd_last;
	end

	`include "ultrasonic_range_scanner_unit_macros.svh"

	`URS_ASSERT(a_wait_to_measure, clk, arst_n, acc && phase_q == PH_WAIT && echo_hi |=> phase_q == PH_MEASURE, "echo seen but no measure")
	`URS_NEVER(a_timer_nonzero, clk, arst_n, phase_q == PH_MEASURE && timer_q == '0, "timer zero while measuring")
	`URS_ASSERT(a_last_to_idle, clk, arst_n, acc && rd_valid && rd_last |=> phase_q == PH_IDLE && sensor_q == '0, "scan did not end")

endmodule

`default_nettype wire

### rtl/urs_out_buf.sv
// ----------------------------------------------------------------------------
// urs_out_buf
// Two-entry result buffer. It parts the sequencer from the result channel so
// that ticks keep flowing while a result beat waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module urs_out_buf (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	input  urs_pkg::res_t  push_data,
	output logic           full,
	output logic           res_valid,
	input  wire            res_stall,
	output urs_pkg::res_t  res_data
);
	import urs_pkg::*;

	res_t       ent_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign res_valid = (cnt_q != 2'd0);
	assign full      = (cnt_q == 2'd2);
	assign pop       = res_valid && !res_stall;
	assign res_data  = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	`include "ultrasonic_range_scanner_unit_macros.svh"

	`URS_NEVER(a_push_full, clk, arst_n, push && full, "push into full buffer")
	`URS_NEVER(a_cnt_range, clk, arst_n, cnt_q == 2'd3, "count out of range")
	`URS_ASSERT(a_pop_only, clk, arst_n, pop && !push |=> cnt_q == $past(cnt_q) - 2'd1, "count not lowered")

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the ultrasonic range scanner.
// ----------------------------------------------------------------------------
// Every input beat is one microsecond tick. A behavioral scan sequencer
// inside the bench tracks the trigger timing and echo timing of each sensor.
// It predicts the result beat that every tick produces, and each result
// beat is compared with those predictions in order. A short hand-written
// sequence comes first. Random scans under several trigger timings follow,
// most with gaps and stalls on both channels, and a final stretch runs
// with no gaps at all.
// ----------------------------------------------------------------------------

module tb;
	import urs_pkg::*;

	localparam int SENSORS     = 3;
	localparam int TIMER_W     = 16;
	localparam int LONG_HOLD   = 40;
	localparam int CYCLE_LIMIT = 1000000;

	typedef enum logic [2:0] {
		SC_IDLE,
		SC_LOW,
		SC_HIGH,
		SC_WAIT,
		SC_MEASURE
	} scan_phase_t;

	typedef struct packed {
		item_t beat;
		logic  pinned;
		res_t  want;
	} opening_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_TRIG_LOW;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 item_valid = 1'b0;
	logic                 item_stall;
	item_t                item_data = '0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	res_t                 res_data;

	// Sequencer state that the prediction keeps in step with the block.
	logic [CFG_W-1:0]   trig_low_set = TRIG_LOW_RST;
	logic [CFG_W-1:0]   trig_high_set = TRIG_HIGH_RST;
	scan_phase_t        scan_phase = SC_IDLE;
	logic [1:0]         scan_sensor = '0;
	logic [7:0]         phase_ticks = '0;
	logic [TIMER_W-1:0] echo_ticks = '0;

	res_t         tick_results_due[$];
	opening_row_t opening_rows[$];
	int           mismatch_count = 0;
	int           cycle_count = 0;
	int           echo_goal = 1;
	logic         gaps_on = 1'b0;
	logic         hold_go = 1'b0;

	ultrasonic_range_scanner_unit #(
		.SENSOR_COUNT(SENSORS),
		.TIMER_WIDTH (TIMER_W)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item_data (item_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic item_t mk_item(input logic cmd, input logic [ECHO_W-1:0] echo);
		item_t beat;
		beat.cmd = cmd;
		beat.echo_levels = echo;
		return beat;
	endfunction

	function automatic res_t mk_res(input logic [TRIG_W-1:0] trig, input logic busy,
			input logic valid, input logic [SENSOR_W-1:0] sensor,
			input logic [DIST_W-1:0] cm, input logic [31:0] ascii, input logic last);
		res_t r;
		r.trigger_lines = trig;
		r.busy_res = busy;
		r.reading_valid = valid;
		r.sensor_number = sensor;
		r.distance_cm = cm;
		r.ascii_digits = ascii;
		r.scan_last = last;
		return r;
	endfunction

	function automatic string show(input res_t r);
		return $sformatf("trig=%b busy=%b valid=%b sensor=%0d dist=%0d ascii=%h last=%b",
			r.trigger_lines, r.busy_res, r.reading_valid, r.sensor_number,
			r.distance_cm, r.ascii_digits, r.scan_last);
	endfunction

	function automatic logic [31:0] digits_of(input int unsigned cm);
		logic [31:0] word;
		int unsigned v;
		v = cm % 10000;
		word = '0;
		for (int i = 0; i < 4; i++) begin
			word[8*i +: 8] = ASCII_ZERO + 8'(v % 10);
			v = v / 10;
		end
		return word;
	endfunction

	function automatic void open_sensor();
		phase_ticks = '0;
		echo_ticks = '0;
		scan_phase = (trig_low_set == 0) ? SC_HIGH : SC_LOW;
	endfunction

	// Advances the sequencer by one tick and returns the result it produces.
	function automatic res_t predict_tick(input item_t beat);
		res_t r;
		logic echo_hi;
		logic [TIMER_W-1:0] span;
		r = '0;
		echo_hi = (scan_sensor < ECHO_W) && beat.echo_levels[scan_sensor];
		case (scan_phase)
			SC_IDLE: begin
				if (beat.cmd) begin
					scan_sensor = '0;
					open_sensor();
				end
			end
			SC_LOW: begin
				phase_ticks = phase_ticks + 8'd1;
				if (phase_ticks >= trig_low_set) begin
					scan_phase = SC_HIGH;
					phase_ticks = '0;
				end
			end
			SC_HIGH: begin
				phase_ticks = phase_ticks + 8'd1;
				if (phase_ticks >= trig_high_set) begin
					scan_phase = SC_WAIT;
					phase_ticks = '0;
				end
			end
			SC_WAIT: begin
				if (echo_hi) begin
					echo_ticks = TIMER_W'(1);
					scan_phase = SC_MEASURE;
				end
			end
			SC_MEASURE: begin
				if (echo_hi) begin
					if (echo_ticks != '1)
						echo_ticks = echo_ticks + 1'b1;
				end else begin
					span = TIMER_W'(echo_ticks / DIVISOR_CM);
					r.reading_valid = 1'b1;
					r.sensor_number = scan_sensor;
					r.distance_cm = DIST_W'(span);
					r.ascii_digits = digits_of(span);
					r.scan_last = (scan_sensor + 1 >= SENSORS);
					if (r.scan_last) begin
						scan_phase = SC_IDLE;
						scan_sensor = '0;
						phase_ticks = '0;
						echo_ticks = '0;
					end else begin
						scan_sensor = scan_sensor + 2'd1;
						open_sensor();
					end
				end
			end
			default: scan_phase = SC_IDLE;
		endcase
		if (scan_phase == SC_HIGH && scan_sensor < TRIG_W)
			r.trigger_lines = TRIG_W'(1) << scan_sensor;
		r.busy_res = (scan_phase != SC_IDLE);
		return r;
	endfunction

	// Mostly well-formed echoes for the sensor being measured, with random
	// levels on the other lines and now and then a fully random tick.
	function automatic item_t pick_tick(input logic may_start);
		item_t beat;
		logic noise;
		beat.cmd = 1'($urandom_range(0, 1));
		beat.echo_levels = ECHO_W'($urandom_range(0, 7));
		noise = ($urandom_range(0, 15) == 0);
		case (scan_phase)
			SC_IDLE: beat.cmd = may_start && ($urandom_range(0, 3) == 0);
			SC_WAIT: begin
				if (!noise) begin
					beat.echo_levels[scan_sensor] = ($urandom_range(0, 2) == 0);
					if (beat.echo_levels[scan_sensor])
						echo_goal = ($urandom_range(0, 9) == 0) ?
							$urandom_range(120, 700) : $urandom_range(1, 120);
				end
			end
			SC_MEASURE: begin
				if (!noise)
					beat.echo_levels[scan_sensor] = (echo_ticks < echo_goal);
			end
			default: ;
		endcase
		return beat;
	endfunction

	task automatic send_tick(input item_t beat, input logic pinned = 1'b0,
			input res_t want = '0);
		res_t predicted;
		logic taken;
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item_data <= beat;
		do begin
			@(negedge clk);
			taken = (item_stall === 1'b0);
			@(posedge clk);
		end while (!taken);
		predicted = predict_tick(beat);
		tick_results_due.push_back(pinned ? want : predicted);
	endtask

	task automatic set_timing(input logic [CFG_W-1:0] low_us, input logic [CFG_W-1:0] high_us);
		item_valid <= 1'b0;
		while (tick_results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_TRIG_LOW;
		cfg_data <= low_us;
		@(posedge clk);
		cfg_index <= CFG_TRIG_HIGH;
		cfg_data <= high_us;
		@(posedge clk);
		cfg_we <= 1'b0;
		trig_low_set = low_us;
		trig_high_set = high_us;
	endtask

	// Each phase opens with a scan request and ends once the scan in flight
	// has finished, so the next register write lands on an idle block.
	task automatic run_phase(input logic [CFG_W-1:0] low_us, input logic [CFG_W-1:0] high_us,
			input int quota, input logic gaps, input logic squeeze);
		int sent;
		set_timing(low_us, high_us);
		gaps_on = gaps;
		hold_go = squeeze;
		send_tick(mk_item(1'b1, ECHO_W'($urandom_range(0, 7))));
		sent = 1;
		while (sent < quota || scan_phase != SC_IDLE) begin
			send_tick(pick_tick(sent < quota));
			sent++;
		end
	endtask

	initial begin : sink_pacing
		int burst;
		int hold;
		logic nxt;
		burst = 0;
		hold = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				nxt = 1'b1;
			end else if (hold_go) begin
				hold_go = 1'b0;
				hold = LONG_HOLD - 1;
				nxt = 1'b1;
			end else if (burst > 0) begin
				burst--;
				nxt = 1'b1;
			end else if (gaps_on && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(0, 3);
				nxt = 1'b1;
			end else begin
				nxt = 1'b0;
			end
			res_stall <= nxt;
		end
	end

	always @(negedge clk) begin : result_check
		res_t want;
		string diffs;
		if (arst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0) begin
			if (tick_results_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("ERROR: result beat with nothing pending: %s", show(res_data));
			end else begin
				want = tick_results_due.pop_front();
				diffs = "";
				if (res_data.trigger_lines !== want.trigger_lines)
					diffs = {diffs, " trigger_lines"};
				if (res_data.busy_res !== want.busy_res)
					diffs = {diffs, " busy_res"};
				if (res_data.reading_valid !== want.reading_valid)
					diffs = {diffs, " reading_valid"};
				if (res_data.sensor_number !== want.sensor_number)
					diffs = {diffs, " sensor_number"};
				if (res_data.distance_cm !== want.distance_cm)
					diffs = {diffs, " distance_cm"};
				if (res_data.ascii_digits !== want.ascii_digits)
					diffs = {diffs, " ascii_digits"};
				if (res_data.scan_last !== want.scan_last)
					diffs = {diffs, " scan_last"};
				if (diffs != "") begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("ERROR: mismatch in%s", diffs);
						$display("  expected %s", show(want));
						$display("  actual   %s", show(res_data));
					end
				end
			end
		end
	end

	initial begin : stimulus
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero low time and zero high time: the pulse starts on the request
		// tick and lasts one tick. Echo widths of one and two ticks.
		set_timing(8'd0, 8'd0);
		gaps_on = 1'b1;
		opening_rows.push_back({mk_item(1'b0, 3'b111), 1'b1,
			mk_res(3'b000, 1'b0, 1'b0, 2'd0, 19'd0, 32'd0, 1'b0)});
		opening_rows.push_back({mk_item(1'b1, 3'b000), 1'b1,
			mk_res(3'b001, 1'b1, 1'b0, 2'd0, 19'd0, 32'd0, 1'b0)});
		// A request while busy is ignored.
		opening_rows.push_back({mk_item(1'b1, 3'b111), 1'b1,
			mk_res(3'b000, 1'b1, 1'b0, 2'd0, 19'd0, 32'd0, 1'b0)});
		opening_rows.push_back({mk_item(1'b0, 3'b110), 1'b1,
			mk_res(3'b000, 1'b1, 1'b0, 2'd0, 19'd0, 32'd0, 1'b0)});
		opening_rows.push_back({mk_item(1'b0, 3'b001), 1'b0, res_t'('0)});
		opening_rows.push_back({mk_item(1'b1, 3'b001), 1'b0, res_t'('0)});
		opening_rows.push_back({mk_item(1'b0, 3'b110), 1'b1,
			mk_res(3'b010, 1'b1, 1'b1, 2'd0, 19'd0, 32'h30303030, 1'b0)});
		opening_rows.push_back({mk_item(1'b0, 3'b000), 1'b0, res_t'('0)});
		opening_rows.push_back({mk_item(1'b0, 3'b101), 1'b0, res_t'('0)});
		opening_rows.push_back({mk_item(1'b0, 3'b010), 1'b0, res_t'('0)});
		opening_rows.push_back({mk_item(1'b0, 3'b010), 1'b0, res_t'('0)});
		opening_rows.push_back({mk_item(1'b0, 3'b101), 1'b1,
			mk_res(3'b100, 1'b1, 1'b1, 2'd1, 19'd0, 32'h30303030, 1'b0)});
		opening_rows.push_back({mk_item(1'b0, 3'b000), 1'b0, res_t'('0)});
		opening_rows.push_back({mk_item(1'b0, 3'b100), 1'b0, res_t'('0)});
		// The last reading of a scan already shows the block as not busy.
		opening_rows.push_back({mk_item(1'b1, 3'b011), 1'b1,
			mk_res(3'b000, 1'b0, 1'b1, 2'd2, 19'd0, 32'h30303030, 1'b1)});
		opening_rows.push_back({mk_item(1'b0, 3'b111), 1'b1,
			mk_res(3'b000, 1'b0, 1'b0, 2'd0, 19'd0, 32'd0, 1'b0)});
		foreach (opening_rows[i])
			send_tick(opening_rows[i].beat, opening_rows[i].pinned, opening_rows[i].want);

		run_phase(TRIG_LOW_RST, TRIG_HIGH_RST, 350, 1'b1, 1'b0);
		run_phase(8'd0, 8'd1, 300, 1'b1, 1'b1);
		run_phase(8'd255, 8'd255, 0, 1'b1, 1'b0);
		run_phase(8'd9, 8'd3, 350, 1'b0, 1'b0);
		run_phase(8'($urandom_range(0, 31)), 8'($urandom_range(0, 31)), 300, 1'b1, 1'b0);

		run_phase(TRIG_LOW_RST, TRIG_HIGH_RST, 150, 1'b0, 1'b0);

		item_valid <= 1'b0;
		while (tick_results_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
